/* hw/rtl/hfas_pkg.sv */
// Shared constants, coefficient table and types for the Hilbert FIR analytic-signal block.
// No dependencies; imported by hfas_cell and the top level.
package hfas_pkg;

  localparam int TAPS       = 32;
  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 2 * SAMPLE_W + $clog2(TAPS);
  localparam int CNT_W      = $clog2(TAPS + 1);
  localparam int CENTER_DLY = TAPS - 1 - TAPS / 2;
  localparam int FRAC_SHIFT = 15;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  typedef logic signed [SAMPLE_W-1:0] coef_arr_t [TAPS];

  // restoring divide, elaboration only
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint series_q30(input longint unsigned a, input bit want_sin);
    longint unsigned a2;
    longint unsigned term;
    longint unsigned n;
    longint          sum;
    a2   = (a * a) >> 30;
    term = want_sin ? a : ONE_Q30;
    sum  = longint'(term);
    n    = want_sin ? 64'd1 : 64'd0;
    for (int i = 0; i < 15; i++) begin
      term = (term * a2) >> 30;
      term = udiv64(term, (n + 64'd1) * (n + 64'd2));
      n    = n + 64'd2;
      if ((i % 2) == 0) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    return sum;
  endfunction

  function automatic int cot_coef(input int m);
    longint unsigned a;
    longint          s;
    longint          c;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    a = udiv64(PI_Q30 * longint'(m) + longint'(TAPS / 2), longint'(TAPS));
    s = series_q30(a, 1'b1);
    c = series_q30(a, 1'b0);
    if (s <= 0 || c <= 0) return 0;
    num = longint'(c) << 16;
    den = longint'(TAPS) * longint'(s);
    q   = udiv64(2 * num + den, 2 * den);
    if (q > 64'd32767) q = 64'd32767;
    return int'(q);
  endfunction

  function automatic int h_value(input int k);
    if ((k % 2) == 0 || 2 * k == TAPS) return 0;
    if (2 * k < TAPS) return cot_coef(k);
    return -cot_coef(TAPS - k);
  endfunction

  function automatic coef_arr_t build_coefs();
    coef_arr_t t;
    for (int j = 0; j < TAPS; j++) begin
      t[j] = SAMPLE_W'(h_value(TAPS - 1 - j));
    end
    return t;
  endfunction

  // COEF[j] = h[TAPS-1-j]; h[0] is zero by construction
  localparam coef_arr_t COEF = build_coefs();

endpackage

/* hw/rtl/hfas_cell.sv */
// One tap of the transposed Hilbert FIR: a sample delay stage and a partial-sum stage.
// Depends on hfas_pkg.
module hfas_cell import hfas_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic signed [SAMPLE_W-1:0] x,
  input  logic signed [SAMPLE_W-1:0] coef,
  input  logic signed [SAMPLE_W-1:0] d_in,
  input  logic signed [ACC_W-1:0]    sum_in,
  output logic signed [SAMPLE_W-1:0] d_out,
  output logic signed [ACC_W-1:0]    sum_out
);

  logic signed [2*SAMPLE_W-1:0] prod;
  logic signed [ACC_W-1:0]      sum_nxt;
  logic signed [ACC_W-1:0]      sum_r;
  logic signed [SAMPLE_W-1:0]   d_r;

  assign prod    = x * coef;
  assign sum_nxt = sum_in + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      d_r   <= '0;
    end else if (en) begin
      sum_r <= sum_nxt;
      d_r   <= d_in;
    end
  end

  assign sum_out = sum_r;
  assign d_out   = d_r;

endmodule

/* hw/rtl/hilbert_fir_analytic_signal_top.sv */
// Hilbert FIR analytic-signal generator: row of TAPS-1 transposed-FIR cells plus output stage.
// Depends on hfas_pkg and hfas_cell.
// The result is registered at the accepting edge of the sample that completes it.
// Throughput: 1 item per cycle if out_ready is high; cells advance only on an accepted item.
// Results start once TAPS samples have arrived since reset or since a first flag.
// Reset (sync, active low) clears the fill count, cell row and out_valid, not result data.
module hilbert_fir_analytic_signal_top import hfas_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_first_sample,
  input  logic                       in_last_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_real_part,
  output logic signed [SAMPLE_W-1:0] out_imag_part,
  output logic                       out_last_out
);

  logic signed [ACC_W-1:0]    sum_w [1:TAPS];
  logic signed [SAMPLE_W-1:0] d_w   [0:TAPS-1];

  logic                       in_fire;
  logic [CNT_W-1:0]           fill_cnt_r;
  logic [CNT_W-1:0]           cnt_base;
  logic [CNT_W-1:0]           fill_cnt_nxt;
  logic                       full_nxt;
  logic signed [ACC_W-1:0]    shifted;
  logic [ACC_W-SAMPLE_W:0]    hi_bits;
  logic signed [SAMPLE_W-1:0] imag_nxt;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] real_r;
  logic signed [SAMPLE_W-1:0] imag_r;
  logic                       last_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign sum_w[TAPS] = '0;
  assign d_w[0]      = in_sample;

  for (genvar k = 1; k < TAPS; k++) begin : g_cell
    hfas_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (in_fire),
      .x       (in_sample),
      .coef    (COEF[TAPS-1-k]),
      .d_in    (d_w[k-1]),
      .sum_in  (sum_w[k+1]),
      .d_out   (d_w[k]),
      .sum_out (sum_w[k])
    );
  end

  // h[0] is zero, so the sum for the current item is the first cell's partial sum
  assign shifted = sum_w[1] >>> FRAC_SHIFT;
  assign hi_bits = shifted[ACC_W-1:SAMPLE_W-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      imag_nxt = shifted[SAMPLE_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      imag_nxt = SAMPLE_MIN;
    end else begin
      imag_nxt = SAMPLE_MAX;
    end
  end

  assign cnt_base     = in_first_sample ? '0 : fill_cnt_r;
  assign fill_cnt_nxt = (cnt_base < CNT_W'(TAPS)) ? cnt_base + CNT_W'(1) : cnt_base;
  assign full_nxt     = (fill_cnt_nxt == CNT_W'(TAPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        fill_cnt_r  <= fill_cnt_nxt;
        out_valid_r <= full_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && full_nxt) begin
      real_r <= d_w[CENTER_DLY];
      imag_r <= imag_nxt;
      last_r <= in_last_sample;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_real_part = real_r;
  assign out_imag_part = imag_r;
  assign out_last_out  = last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= CNT_W'(TAPS))
    else $error("fill count above TAPS");

  a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_first_sample |=> fill_cnt_r == CNT_W'(1) && !out_valid)
    else $error("first flag did not restart the window fill");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_first_sample && fill_cnt_r == CNT_W'(TAPS) |=> out_valid)
    else $error("full window gave no result");

endmodule
